>>> hdl/lmoc_pkg.sv
// Package for the LED mode and one-shot controller.
// Holds shared types, codes, constants and the time clamp; no dependencies.
package lmoc_pkg;

  localparam int unsigned MaxLeds  = 10;
  localparam int unsigned LedAw    = 4;
  localparam logic [14:0] TimeMax  = 15'h7fff;
  localparam logic [14:0] TimeMin  = 15'd50;

  typedef enum logic [3:0] {
    ACT_LEVEL  = 4'd0,
    ACT_COLOR  = 4'd1,
    ACT_ON     = 4'd2,
    ACT_OFF    = 4'd3,
    ACT_BLINK  = 4'd4,
    ACT_BREATH = 4'd5,
    ACT_PULSE  = 4'd6,
    ACT_SHOT   = 4'd7,
    ACT_STATUS = 4'd8,
    ACT_TICK   = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    KIND_ONOFF  = 3'd0,
    KIND_BLINK  = 3'd1,
    KIND_BREATH = 3'd2,
    KIND_LEVEL  = 3'd3,
    KIND_COLOR  = 3'd4,
    KIND_STATUS = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  localparam logic [1:0] ModeOff    = 2'd0;
  localparam logic [1:0] ModeOn     = 2'd1;
  localparam logic [1:0] ModeBlink  = 2'd2;
  localparam logic [1:0] ModeBreath = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  level;
    logic [23:0] color;
    logic [14:0] on_ms;
    logic [14:0] off_ms;
  } setting_t;

  // One LED entry: wanted, shown, pulse.
  typedef struct packed {
    setting_t    want;
    setting_t    shown;
    logic        armed;
    logic [31:0] start;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  target;
    logic        turn_on;
    logic [1:0]  mode;
    logic [7:0]  level;
    logic [23:0] color;
    logic [14:0] on_ms;
    logic [14:0] off_ms;
    logic        present;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_EMIT, ST_WRITE
  } state_e;

  function automatic logic [14:0] clamp_time(input logic [15:0] t);
    if (t < {1'b0, TimeMin}) return TimeMin;
    if (t > {1'b0, TimeMax}) return TimeMax;
    return t[14:0];
  endfunction

endpackage

>>> hdl/led_mode_oneshot_controller_unit.sv
// Top level of the LED mode and one-shot controller.
// Uses lmoc_pkg and one lmoc_ram holding all per-LED state.
//
// After reset a clearing pass zeroes all 16 entries of the LED memory; no
// item is taken meanwhile. A command passes through accept, read, execute
// and write back; a status or error result must be taken before the next
// item is accepted. A tick walks the LEDs, each through read, execute, two
// or four emit phases and write back. Each tick result waits in a one-entry
// slot until the next result or the end of the walk shows whether it is the
// last one, then leaves through the output register and waits for
// m_axis_tready. The single memory read port sets the pace.
module led_mode_oneshot_controller_unit
  import lmoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[3:0], led[7:4], level[15:8], red[23:16], green[31:24],
  // blue[39:32], on_time[55:40], off_time[71:56], elapsed_ms[87:72]
  input  logic [87:0] s_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[2:0], target[6:3], turn_on[7], mode_out[9:8], level_out[17:10],
  // red_out[25:18], green_out[33:26], blue_out[41:34], on_ms_out[56:42],
  // off_ms_out[71:57], present[72]; zero up to bit 79
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  state_e      state_q, state_d;
  logic [87:0] in_q;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] clk_ms_q, clk_ms_d;
  logic [3:0]  led_count_q;
  entry_t      ent_q, ent_d;
  logic [2:0]  ph_q, ph_d;
  logic        ovalid_q, ovalid_d;
  result_t     ores_q, ores_d;
  logic        pend_q, pend_d;
  result_t     pres_q, pres_d;
  result_t     nres;
  logic        nvalid;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  lmoc_ram #(.Width(EntryW), .Depth(16)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [3:0]  act, led, count;
  logic [31:0] dlt, cyc;
  logic [1:0]  emode;
  entry_t      re;
  logic        last_led;

  assign act = in_q[3:0];
  assign led = in_q[7:4];
  assign count = (led_count_q > 4'(MaxLeds)) ? 4'(MaxLeds) : led_count_q;
  assign re = entry_t'(rdata);
  assign cfg_ready_o = (state_q == ST_IDLE) && !ovalid_q && !pend_q;
  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q && !pend_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast = ores_q.last;
  assign m_axis_tdata = {7'd0, ores_q.present, ores_q.off_ms, ores_q.on_ms,
                         ores_q.color[7:0], ores_q.color[15:8], ores_q.color[23:16],
                         ores_q.level, ores_q.mode, ores_q.turn_on, ores_q.target,
                         ores_q.kind};

  assign dlt = clk_ms_q - ent_q.start;
  assign cyc = {17'd0, ent_q.want.on_ms} + {17'd0, ent_q.want.off_ms};
  always_comb begin
    emode = ent_q.want.mode;
    if (ent_q.armed) begin
      if (dlt < {17'd0, ent_q.want.on_ms}) emode = ModeOn;
      else if (dlt < cyc) emode = ModeOff;
      else emode = ModeOn;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    clk_ms_d = clk_ms_q;
    ent_d = ent_q;
    ph_d = ph_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ores_d = ores_q;
    pend_d = pend_q;
    pres_d = pres_q;
    nres = '0;
    nvalid = 1'b0;
    we = 1'b0;
    waddr = idx_q;
    wdata = ent_q;
    raddr = idx_q;
    last_led = (idx_q + 4'd1 >= count);
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pend_q) begin
          // The walk has ended, so the waiting tick result is the last one.
          if (!ovalid_q || m_axis_tready) begin
            ores_d = pres_q;
            ores_d.last = 1'b1;
            ovalid_d = 1'b1;
            pend_d = 1'b0;
          end
        end else if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tdata[3:0] == ACT_TICK) begin
            clk_ms_d = clk_ms_q + {16'd0, s_axis_tdata[87:72]};
            idx_d = '0;
            if (count == 4'd0) state_d = ST_IDLE;
            else state_d = ST_READ;
          end else if (s_axis_tdata[7:4] >= 4'(MaxLeds) || s_axis_tdata[3:0] > ACT_TICK) begin
            ores_d = '0;
            ores_d.kind = KIND_ERROR;
            ores_d.target = s_axis_tdata[7:4];
            ores_d.last = 1'b1;
            ovalid_d = 1'b1;
          end else begin
            idx_d = s_axis_tdata[7:4];
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ent_d = re;
        ph_d = '0;
        if (act == ACT_TICK) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_WRITE;
          case (act)
            ACT_LEVEL: begin
              if (in_q[15:8] == 8'd0) ent_d.want.mode = ModeOff;
              else begin
                if (re.want.mode == ModeOff) ent_d.want.mode = ModeOn;
                ent_d.want.level = in_q[15:8];
              end
            end
            ACT_COLOR: if (in_q[39:16] != 24'd0)
              ent_d.want.color = {in_q[23:16], in_q[31:24], in_q[39:32]};
            ACT_ON: begin ent_d.armed = 1'b0; ent_d.want.mode = ModeOn; end
            ACT_OFF: begin ent_d.armed = 1'b0; ent_d.want.mode = ModeOff; end
            ACT_BLINK, ACT_BREATH: begin
              ent_d.armed = 1'b0;
              ent_d.want.mode = (act == ACT_BLINK) ? ModeBlink : ModeBreath;
              ent_d.want.on_ms = clamp_time(in_q[55:40]);
              ent_d.want.off_ms = clamp_time(in_q[71:56]);
            end
            ACT_PULSE: begin
              ent_d.armed = 1'b1;
              ent_d.want.on_ms = clamp_time(in_q[55:40]);
              ent_d.want.off_ms = clamp_time(in_q[71:56]);
            end
            ACT_SHOT: ph_d = 3'd1;
            ACT_STATUS: begin
              ores_d = '0;
              ores_d.kind = KIND_STATUS;
              ores_d.target = led;
              ores_d.mode = re.shown.mode;
              ores_d.level = re.shown.level;
              ores_d.color = re.shown.color;
              ores_d.on_ms = re.shown.on_ms;
              ores_d.off_ms = re.shown.off_ms;
              ores_d.present = (led < led_count_q);
              ores_d.last = 1'b1;
              ovalid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        // Phases: 0 mode, 1 level, 2 color, 3 write back.
        if (!pend_q || !ovalid_q || m_axis_tready) begin
          nres.target = idx_q;
          case (ph_q)
            3'd0: begin
              ph_d = 3'd1;
              if (emode != ent_q.shown.mode) begin
                ent_d.shown.mode = emode;
                nvalid = 1'b1;
                if (emode == ModeOff || emode == ModeOn) begin
                  nres.kind = KIND_ONOFF;
                  nres.turn_on = (emode == ModeOn);
                end else begin
                  nres.kind = (emode == ModeBlink) ? KIND_BLINK : KIND_BREATH;
                  nres.on_ms = ent_q.want.on_ms;
                  nres.off_ms = ent_q.want.off_ms;
                  ent_d.shown.on_ms = ent_q.want.on_ms;
                  ent_d.shown.off_ms = ent_q.want.off_ms;
                end
                if (emode == ModeOff) ph_d = 3'd3;
              end
            end
            3'd1: begin
              ph_d = 3'd2;
              if (ent_q.want.level != ent_q.shown.level) begin
                ent_d.shown.level = ent_q.want.level;
                nres.kind = KIND_LEVEL;
                nres.level = ent_q.want.level;
                nvalid = 1'b1;
              end
            end
            3'd2: begin
              ph_d = 3'd3;
              if (ent_q.want.color != ent_q.shown.color) begin
                ent_d.shown.color = ent_q.want.color;
                nres.kind = KIND_COLOR;
                nres.color = ent_q.want.color;
                nvalid = 1'b1;
              end
            end
            default: begin
              state_d = ST_WRITE;
            end
          endcase
          if (nvalid) begin
            if (pend_q) begin
              ores_d = pres_q;
              ovalid_d = 1'b1;
            end
            pres_d = nres;
            pend_d = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        if (act == ACT_SHOT && ph_q == 3'd1 && (dlt > cyc || !ent_q.armed))
          wdata = entry_t'{want: ent_q.want, shown: ent_q.shown, armed: ent_q.armed,
                           start: clk_ms_q};
        if (act == ACT_TICK && !last_led) begin
          idx_d = idx_q + 4'd1;
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q <= '0;
      idx_q <= '0;
      clk_ms_q <= '0;
      led_count_q <= 4'(MaxLeds);
      ovalid_q <= 1'b0;
      ph_q <= '0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      clk_ms_q <= clk_ms_d;
      ovalid_q <= ovalid_d;
      ph_q <= ph_d;
      pend_q <= pend_d;
      if (cfg_valid_i && cfg_ready_o) led_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    ores_q <= ores_d;
    pres_q <= pres_d;
    if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == ST_WRITE || state_q == ST_CLEAR)
    else $error("memory written outside write back");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_q && state_q == ST_IDLE)
    else $error("item taken while busy");
endmodule

>>> hdl/lmoc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lmoc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> tb/lmoc_checker.sv
// Checker for the LED mode and one-shot controller: watches the input, config
// and result channels, predicts every result and compares it field by field.
// Depends on lmoc_pkg for the setting and result types and the code enums.
module lmoc_checker
  import lmoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [87:0] s_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [79:0] m_data_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [3:0]  led_count;
  setting_t    want [MaxLeds];
  setting_t    shown [MaxLeds];
  logic        armed [MaxLeds];
  logic [31:0] start [MaxLeds];
  logic [31:0] clock_ms;
  result_t     device_cmd_q[$];

  function automatic logic [14:0] clamp_duration(input logic [15:0] t);
    logic [14:0] r;
    r = t[14:0];
    if (t < 16'd50) r = 15'd50;
    else if (t[15]) r = 15'h7fff;
    return r;
  endfunction

  task automatic add_cmd(input kind_e kind, input logic [3:0] target, input logic turn_on,
                         input logic [1:0] mode, input logic [7:0] level,
                         input logic [23:0] color, input logic [14:0] on_ms,
                         input logic [14:0] off_ms, input logic present);
    result_t r;
    r.kind = kind;
    r.target = target;
    r.turn_on = turn_on;
    r.mode = mode;
    r.level = level;
    r.color = color;
    r.on_ms = on_ms;
    r.off_ms = off_ms;
    r.present = present;
    r.last = 1'b0;
    device_cmd_q.push_back(r);
  endtask

  task automatic run_tick(input logic [15:0] elapsed);
    int          cnt;
    logic [1:0]  m;
    logic [31:0] d;
    logic [31:0] cyc;
    cnt = (led_count > MaxLeds) ? MaxLeds : led_count;
    clock_ms = clock_ms + {16'd0, elapsed};
    for (int i = 0; i < cnt; i++) begin
      m = want[i].mode;
      if (armed[i]) begin
        d = clock_ms - start[i];
        cyc = {17'd0, want[i].on_ms} + {17'd0, want[i].off_ms};
        if (d < {17'd0, want[i].on_ms}) m = ModeOn;
        else if (d < cyc) m = ModeOff;
        else m = ModeOn;
      end
      if (m != shown[i].mode) begin
        shown[i].mode = m;
        if (m == ModeOff) begin
          add_cmd(KIND_ONOFF, i[3:0], 1'b0, 2'd0, 8'd0, 24'd0, 15'd0, 15'd0, 1'b0);
          continue;
        end else if (m == ModeOn) begin
          add_cmd(KIND_ONOFF, i[3:0], 1'b1, 2'd0, 8'd0, 24'd0, 15'd0, 15'd0, 1'b0);
        end else begin
          shown[i].on_ms = want[i].on_ms;
          shown[i].off_ms = want[i].off_ms;
          add_cmd((m == ModeBlink) ? KIND_BLINK : KIND_BREATH, i[3:0], 1'b0, 2'd0, 8'd0,
                  24'd0, want[i].on_ms, want[i].off_ms, 1'b0);
        end
      end
      if (want[i].level != shown[i].level) begin
        shown[i].level = want[i].level;
        add_cmd(KIND_LEVEL, i[3:0], 1'b0, 2'd0, want[i].level, 24'd0, 15'd0, 15'd0, 1'b0);
      end
      if (want[i].color != shown[i].color) begin
        shown[i].color = want[i].color;
        add_cmd(KIND_COLOR, i[3:0], 1'b0, 2'd0, 8'd0, want[i].color, 15'd0, 15'd0, 1'b0);
      end
    end
  endtask

  task automatic apply_command(input logic [87:0] item);
    logic [3:0]  act;
    logic [3:0]  led;
    logic [23:0] color;
    logic [31:0] d;
    logic [31:0] cyc;
    int          before_n;
    result_t     r;
    act = item[3:0];
    led = item[7:4];
    color = {item[23:16], item[31:24], item[39:32]};
    before_n = device_cmd_q.size();
    if (act == ACT_TICK) begin
      run_tick(item[87:72]);
    end else if (led >= MaxLeds || act > ACT_TICK) begin
      add_cmd(KIND_ERROR, led, 1'b0, 2'd0, 8'd0, 24'd0, 15'd0, 15'd0, 1'b0);
    end else begin
      case (act)
        ACT_LEVEL: begin
          if (item[15:8] == 8'd0) begin
            want[led].mode = ModeOff;
          end else begin
            if (want[led].mode == ModeOff) want[led].mode = ModeOn;
            want[led].level = item[15:8];
          end
        end
        ACT_COLOR: if (color != 24'd0) want[led].color = color;
        ACT_ON: begin
          armed[led] = 1'b0;
          want[led].mode = ModeOn;
        end
        ACT_OFF: begin
          armed[led] = 1'b0;
          want[led].mode = ModeOff;
        end
        ACT_BLINK, ACT_BREATH: begin
          armed[led] = 1'b0;
          want[led].mode = (act == ACT_BLINK) ? ModeBlink : ModeBreath;
          want[led].on_ms = clamp_duration(item[55:40]);
          want[led].off_ms = clamp_duration(item[71:56]);
        end
        ACT_PULSE: begin
          want[led].on_ms = clamp_duration(item[55:40]);
          want[led].off_ms = clamp_duration(item[71:56]);
          armed[led] = 1'b1;
        end
        ACT_SHOT: begin
          d = clock_ms - start[led];
          cyc = {17'd0, want[led].on_ms} + {17'd0, want[led].off_ms};
          if (d > cyc || !armed[led]) start[led] = clock_ms;
        end
        default: begin
          add_cmd(KIND_STATUS, led, 1'b0, shown[led].mode, shown[led].level,
                  shown[led].color, shown[led].on_ms, shown[led].off_ms, led < led_count);
        end
      endcase
    end
    if (device_cmd_q.size() > before_n) begin
      r = device_cmd_q.pop_back();
      r.last = 1'b1;
      device_cmd_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    result_t e;
    if (device_cmd_q.size() == 0) begin
      $error("unexpected result item: tdata %h", m_data_i);
      fail_count_o++;
      return;
    end
    e = device_cmd_q.pop_front();
    check_field("kind", e.kind, m_data_i[2:0]);
    check_field("target", e.target, m_data_i[6:3]);
    check_field("turn_on", e.turn_on, m_data_i[7]);
    check_field("mode_out", e.mode, m_data_i[9:8]);
    check_field("level_out", e.level, m_data_i[17:10]);
    check_field("red_out", e.color[23:16], m_data_i[25:18]);
    check_field("green_out", e.color[15:8], m_data_i[33:26]);
    check_field("blue_out", e.color[7:0], m_data_i[41:34]);
    check_field("on_ms_out", e.on_ms, m_data_i[56:42]);
    check_field("off_ms_out", e.off_ms, m_data_i[71:57]);
    check_field("present", e.present, m_data_i[72]);
    check_field("pad", 32'd0, m_data_i[79:73]);
    check_field("last", e.last, m_last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count <= 4'd10;
      clock_ms <= '0;
      for (int i = 0; i < MaxLeds; i++) begin
        want[i] <= '0;
        shown[i] <= '0;
        armed[i] <= 1'b0;
        start[i] <= '0;
      end
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) led_count = cfg_data_i;
      if (s_valid_i && s_ready_i) apply_command(s_data_i);
      if (m_valid_i && m_ready_i) check_result();
      pending_o = device_cmd_q.size();
    end
  end

endmodule

>>> tb/tb_led_mode_oneshot_controller_unit.sv
// Testbench top for the LED mode and one-shot controller: drives directed and
// random commands, config writes and random stalls; lmoc_checker predicts and
// compares. Depends on lmoc_pkg, lmoc_checker and the controller RTL.
module tb_led_mode_oneshot_controller_unit;
  import lmoc_pkg::*;

  localparam logic [3:0] ActUnknown = 4'd12;
  localparam logic [3:0] BadLed = 4'd15;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 48;
  bit          hold_req = 1'b0;
  int          stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  led_mode_oneshot_controller_unit uut (.*);

  lmoc_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("** led_mode_oneshot_controller_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_axis_tready = 1'b0;
      repeat (300) @(negedge clk_i);
      hold_req = 1'b0;
    end
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [87:0] make_cmd(input logic [3:0] act, input logic [3:0] led,
                                           input logic [7:0] level, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [15:0] on_t, input logic [15:0] off_t,
                                           input logic [15:0] el);
    return {el, off_t, on_t, b, g, r, level, led, act};
  endfunction

  task automatic send_cmd(input logic [87:0] item);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tdata = item;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_led_count(input logic [3:0] value);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] rand_time();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1200));
  endfunction

  function automatic logic [87:0] rand_cmd();
    logic [3:0] act;
    logic [3:0] led;
    int         p;
    p = $urandom_range(99);
    if (p < 28) act = ACT_TICK;
    else if (p < 33) act = 4'($urandom);
    else act = 4'($urandom_range(8));
    led = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(MaxLeds - 1));
    return make_cmd(act, led, ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), rand_time(), rand_time(),
                    ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600)));
  endfunction

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) send_cmd(rand_cmd());
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_LEVEL, 0, 8'd255, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_COLOR, 0, 0, 8'd0, 8'd0, 8'd0, 0, 0, 0));
    send_cmd(make_cmd(ACT_COLOR, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0, 0));
    send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 16'd1));
    send_cmd(make_cmd(ACT_LEVEL, 1, 8'd0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_ON, 2, 8'd1, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_OFF, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_BLINK, 3, 0, 0, 0, 0, 16'd0, 16'hffff, 0));
    send_cmd(make_cmd(ACT_BREATH, 9, 0, 0, 0, 0, 16'd50, 16'd32767, 0));
    send_cmd(make_cmd(ACT_PULSE, 4, 0, 0, 0, 0, 16'd100, 16'd200, 0));
    send_cmd(make_cmd(ACT_SHOT, 4, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 16'd120));
    send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 16'd150));
    send_cmd(make_cmd(ACT_SHOT, 4, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 16'hffff));
    send_cmd(make_cmd(ACT_STATUS, 3, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_STATUS, 9, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_STATUS, BadLed, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ActUnknown, 2, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_TICK, BadLed, 0, 0, 0, 0, 0, 0, 16'd5));

    send_idle_pct = 23;
    recv_idle_pct = 48;
    write_led_count(4'd0);
    run_random(15);
    write_led_count(4'd15);
    hold_req = 1'b1;
    run_random(25);
    send_idle_pct = 48;
    recv_idle_pct = 23;
    write_led_count(4'd3);
    run_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_led_count(4'd10);
    run_random(25);

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** led_mode_oneshot_controller_unit: PASSED **");
    end else begin
      $display("** led_mode_oneshot_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> led_mode_oneshot_controller_unit.f
hdl/lmoc_pkg.sv
hdl/lmoc_ram.sv
hdl/led_mode_oneshot_controller_unit.sv
tb/lmoc_checker.sv
tb/tb_led_mode_oneshot_controller_unit.sv
